FILE: design/goal_seek_drive_controller_assert.svh
// Assertion macros for the drive controller checker
`ifndef GOAL_SEEK_DRIVE_CONTROLLER_ASSERT_SVH
`define GOAL_SEEK_DRIVE_CONTROLLER_ASSERT_SVH
`define GSD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("gsd check failed");
`define GSD_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("gsd check failed");
`endif

FILE: design/gsdc_pkg.sv
// ----------------------------------------------------------------------------
// gsdc_pkg
// Constants and the CORDIC arctangent table shared by the drive controller files.
// ----------------------------------------------------------------------------
package gsdc_pkg;
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_ROTATE = 3'd1;
	localparam logic [2:0] MODE_MOVE   = 3'd2;
	localparam logic [2:0] MODE_COAST  = 3'd3;
	localparam logic [2:0] MODE_STOP   = 3'd4;

	localparam logic [2:0] REG_GOAL_X    = 3'd0;
	localparam logic [2:0] REG_GOAL_Y    = 3'd1;
	localparam logic [2:0] REG_TOL       = 3'd2;
	localparam logic [2:0] REG_ANG_THR   = 3'd3;
	localparam logic [2:0] REG_KP_ANGLE  = 3'd4;
	localparam logic [2:0] REG_KP_MOVE   = 3'd5;
	localparam logic [2:0] REG_KP_COAST  = 3'd6;
	localparam logic [2:0] REG_MAX_SPEED = 3'd7;

	localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic [19:0] INV_GAIN_Q20 = 20'd636751;
	localparam int GUARD_BITS = 4;

	function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 32'sd843314857;
			5'd1: atan_q30 = 32'sd497837829;
			5'd2: atan_q30 = 32'sd263043837;
			5'd3: atan_q30 = 32'sd133525159;
			5'd4: atan_q30 = 32'sd67021687;
			5'd5: atan_q30 = 32'sd33543516;
			5'd6: atan_q30 = 32'sd16775851;
			5'd7: atan_q30 = 32'sd8388437;
			5'd8: atan_q30 = 32'sd4194283;
			5'd9: atan_q30 = 32'sd2097149;
			5'd10: atan_q30 = 32'sd1048576;
			5'd11: atan_q30 = 32'sd524288;
			5'd12: atan_q30 = 32'sd262144;
			5'd13: atan_q30 = 32'sd131072;
			5'd14: atan_q30 = 32'sd65536;
			5'd15: atan_q30 = 32'sd32768;
			5'd16: atan_q30 = 32'sd16384;
			5'd17: atan_q30 = 32'sd8192;
			5'd18: atan_q30 = 32'sd4096;
			5'd19: atan_q30 = 32'sd2048;
			5'd20: atan_q30 = 32'sd1024;
			5'd21: atan_q30 = 32'sd512;
			5'd22: atan_q30 = 32'sd256;
			5'd23: atan_q30 = 32'sd128;
			default: atan_q30 = 32'sd0;
		endcase
	endfunction
endpackage

FILE: design/goal_seek_drive_controller.sv
// ----------------------------------------------------------------------------
// goal_seek_drive_controller
// Point-goal controller: rotate toward the goal, then drive onto it.
// ----------------------------------------------------------------------------
// Usage: one odometry sample (pos_x, pos_y, heading) on the in channel gives
// one command (forward_cmd, turn_cmd, drive_mode, goal_reached,
// command_number) on the out channel. Registers are written on the cfg
// channel (cfg_index, cfg_data) while the block is idle; all eight indexes name a register.
// A pending cfg transfer holds off the next sample: in_ready is low while cfg_valid is high.
// Steps from input transfer to output valid: one shared add/shift step per
// CORDIC rotation, then the distance scale with a first error wrap, the
// error wrap and round (repeated until the error lies within +-pi), the
// threshold compare, the state step with its gain multiply and the output
// round. One sample at a time: in_ready is low from transfer until the
// command has been taken.
// Reset clears the mode to idle, the sequence number to zero and the
// registers to their defaults. A stalled receiver holds the command and
// blocks new samples.
// ----------------------------------------------------------------------------
module goal_seek_drive_controller
	import gsdc_pkg::*;
#(
	parameter int CORDIC_STEPS    = 16,
	parameter int POS_FRAC_BITS   = 16,
	parameter int ANGLE_FRAC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [14:0]  heading,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [30:0]         forward_cmd,
	output logic signed [31:0]  turn_cmd,
	output logic [2:0]          drive_mode,
	output logic                goal_reached,
	output logic [31:0]         command_number
);
	localparam int SW = 5;
	localparam int AW = 36;
	localparam int W = 39;
	localparam int ASH = 30 - ANGLE_FRAC_BITS;
	localparam int TSH = ANGLE_FRAC_BITS + 8 - POS_FRAC_BITS;
	localparam logic [30:0] COAST_MAX = 31'(((3 << POS_FRAC_BITS) + 5) / 10);

	typedef enum logic [2:0] {S_IDLE, S_ITER, S_DIST, S_WRAP, S_MUL, S_DEC, S_CMD,
		S_OUT} state_t;

	state_t state_q;
	logic signed [31:0] goal_x_q, goal_y_q;
	logic [30:0] tol_q, max_speed_q;
	logic [13:0] ang_thr_q;
	logic [15:0] kp_angle_q, kp_move_q, kp_coast_q;
	logic [2:0] mode_q;
	logic [31:0] seq_q;
	logic signed [W-1:0] x_q, y_q;
	logic signed [AW-1:0] z_q;
	logic [SW-1:0] step_q;
	logic signed [14:0] hd_q;
	logic [32:0] dist_q;
	logic signed [AW-1:0] err_q;
	logic signed [50:0] prod_q;
	logic [15:0] aerr_q;
	logic signed [19:0] erra_q;
	logic big_q;

	logic signed [W-1:0] dx, dy, xs, ys;
	logic signed [AW-1:0] hd_ext, e0;
	logic signed [AW:0] eround;
	logic signed [19:0] erra_c;
	logic [W+20-1:0] dprod;
	logic [2:0] nst;
	logic [32:0] dist_ext;
	logic [32:0] coast_thr;
	logic signed [51:0] rnd_t;
	logic signed [51:0] rnd_f;
	logic signed [31:0] turn_c;
	logic [30:0] fwd_c;
	logic [15:0] kp_sel;
	logic [30:0] cap_sel;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = (state_q == S_OUT);

	assign dx = W'(goal_x_q) - W'(pos_x);
	assign dy = W'(goal_y_q) - W'(pos_y);
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign hd_ext = AW'(hd_q) <<< ASH;
	assign e0 = z_q - hd_ext;
	assign dprod = (x_q[W-1] ? '0 : (W+20)'(unsigned'(x_q))) * (W+20)'(INV_GAIN_Q20);
	assign eround = (AW+1)'(err_q) + (AW+1)'(1 <<< (ASH - 1));
	assign erra_c = 20'(eround >>> ASH);
	assign coast_thr = {1'b0, tol_q, 1'b0};
	assign dist_ext = dist_q;
	assign kp_sel = (nst == MODE_MOVE) ? kp_move_q : kp_coast_q;
	assign cap_sel = (drive_mode == MODE_MOVE) ? max_speed_q : COAST_MAX;

	always_comb begin
		case (mode_q)
			MODE_ROTATE:
				nst = big_q ? MODE_ROTATE : (dist_ext > coast_thr) ? MODE_MOVE :
					(dist_ext > 33'(tol_q)) ? MODE_COAST : MODE_STOP;
			MODE_MOVE:
				nst = (dist_ext <= coast_thr) ? MODE_COAST : MODE_MOVE;
			MODE_COAST:
				nst = (dist_ext <= 33'(tol_q)) ? MODE_STOP :
					big_q ? MODE_ROTATE : MODE_COAST;
			MODE_STOP:
				nst = MODE_STOP;
			default:
				nst = big_q ? MODE_ROTATE : (dist_ext > coast_thr) ? MODE_MOVE :
					(dist_ext > 33'(tol_q)) ? MODE_COAST : MODE_STOP;
		endcase
	end

	always_comb begin
		rnd_t = (52'(prod_q) + 52'(TSH > 0 ? (1 <<< (TSH - 1)) : 0)) >>> TSH;
		if (TSH < 0)
			rnd_t = 52'(prod_q) <<< (-TSH);
		if (rnd_t > 52'sd2147483647)
			turn_c = 32'sh7fffffff;
		else if (rnd_t < -52'sd2147483648)
			turn_c = 32'sh80000000;
		else
			turn_c = 32'(rnd_t);
		rnd_f = (52'(prod_q) + 52'sd128) >>> 8;
		if (rnd_f < 0)
			fwd_c = '0;
		else if (rnd_f > 52'(cap_sel))
			fwd_c = cap_sel;
		else
			fwd_c = 31'(rnd_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_IDLE;
			seq_q <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			tol_q <= 31'd32768;
			ang_thr_q <= 14'd410;
			kp_angle_q <= 16'd768;
			kp_move_q <= 16'd51;
			kp_coast_q <= 16'd51;
			max_speed_q <= 31'd65536;
			forward_cmd <= '0;
			turn_cmd <= '0;
			drive_mode <= MODE_IDLE;
			goal_reached <= 1'b0;
			command_number <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_GOAL_X: goal_x_q <= cfg_data;
							REG_GOAL_Y: goal_y_q <= cfg_data;
							REG_TOL: tol_q <= cfg_data[30:0];
							REG_ANG_THR: ang_thr_q <= cfg_data[13:0];
							REG_KP_ANGLE: kp_angle_q <= cfg_data[15:0];
							REG_KP_MOVE: kp_move_q <= cfg_data[15:0];
							REG_KP_COAST: kp_coast_q <= cfg_data[15:0];
							REG_MAX_SPEED: max_speed_q <= cfg_data[30:0];
							default: ;
						endcase
					end
					if (in_valid && in_ready) begin
						hd_q <= heading;
						step_q <= '0;
						if (dx < 0) begin
							x_q <= -(dx <<< GUARD_BITS);
							y_q <= -(dy <<< GUARD_BITS);
							z_q <= (dy >= 0) ? PI_Q30 : -PI_Q30;
						end else begin
							x_q <= dx <<< GUARD_BITS;
							y_q <= dy <<< GUARD_BITS;
							z_q <= '0;
						end
						state_q <= S_ITER;
					end
				end
				S_ITER: begin
					if (y_q >= 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + AW'(atan_q30(step_q));
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - AW'(atan_q30(step_q));
					end
					step_q <= step_q + 1'b1;
					if (32'(step_q) == CORDIC_STEPS - 1)
						state_q <= S_DIST;
				end
				S_DIST: begin
					dist_q <= 33'((dprod + ((W+20)'(1) << (19 + GUARD_BITS)))
						>> (20 + GUARD_BITS));
					if (e0 > PI_Q30)
						err_q <= e0 - TWO_PI_Q30;
					else if (e0 < -PI_Q30)
						err_q <= e0 + TWO_PI_Q30;
					else
						err_q <= e0;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (err_q > PI_Q30)
						err_q <= err_q - TWO_PI_Q30;
					else if (err_q < -PI_Q30)
						err_q <= err_q + TWO_PI_Q30;
					else begin
						erra_q <= erra_c;
						aerr_q <= 16'(erra_c < 0 ? -erra_c : erra_c);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					big_q <= 32'(aerr_q) > 32'(ang_thr_q);
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (nst == MODE_ROTATE)
						prod_q <= 51'($signed({1'b0, kp_angle_q})) * 51'(erra_q);
					else
						prod_q <= 51'($signed({1'b0, kp_sel})) * 51'($signed({1'b0, dist_q}));
					mode_q <= (mode_q == MODE_STOP) ? MODE_IDLE : nst;
					drive_mode <= nst;
					goal_reached <= (mode_q == MODE_STOP);
					command_number <= seq_q;
					seq_q <= seq_q + 1'b1;
					state_q <= S_CMD;
					forward_cmd <= '0;
					turn_cmd <= '0;
				end
				S_CMD: begin
					if (drive_mode == MODE_ROTATE)
						turn_cmd <= turn_c;
					else if (drive_mode == MODE_MOVE || drive_mode == MODE_COAST)
						forward_cmd <= fwd_c;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/gsdc_checker.sv
// ----------------------------------------------------------------------------
// gsdc_checker
// Port-level checks for the drive controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "goal_seek_drive_controller_assert.svh"
module gsdc_checker
	import gsdc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] forward_cmd,
	input logic [31:0] turn_cmd,
	input logic [2:0]  drive_mode,
	input logic        goal_reached
);
	`GSD_ASSERT_IMP(a_busy, clk, arst_n, out_valid, !in_ready)
	`GSD_ASSERT_IMP(a_reach, clk, arst_n, out_valid && goal_reached,
		drive_mode == MODE_STOP && forward_cmd == 0 && turn_cmd == 0)
	`GSD_ASSERT_IMP(a_rot, clk, arst_n, out_valid && drive_mode == MODE_ROTATE,
		forward_cmd == 0)
	`GSD_ASSERT_NXT(a_take, clk, arst_n, in_valid && in_ready, !out_valid)
endmodule

bind goal_seek_drive_controller gsdc_checker u_gsdc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .forward_cmd(forward_cmd),
	.turn_cmd(turn_cmd), .drive_mode(drive_mode), .goal_reached(goal_reached)
);
